@@ hdl/bsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Byte stream reassembler package
// Shared sizes, opcodes and field widths for the reassembler and its checker.
// ----------------------------------------------------------------------------
package bsr_pkg;

  localparam int CAPACITY = 4096;
  localparam int SlotW    = $clog2(CAPACITY);
  localparam int CntW     = $clog2(CAPACITY + 1);
  localparam int IdxW     = 32;
  localparam int CountOutW = 13;
  localparam int InDataW  = 40;
  localparam int OutDataW = 72;

  localparam logic [1:0] OpWrite  = 2'd0;
  localparam logic [1:0] OpEnd    = 2'd1;
  localparam logic [1:0] OpRead   = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

endpackage

@@ hdl/byte_stream_reassembler.sv @@
// ----------------------------------------------------------------------------
// Byte stream reassembler
// Rebuilds an in-order byte stream from indexed bytes in a ring buffer.
// ----------------------------------------------------------------------------
// States from request to result: end mark StIdle, StFin; read StIdle, StRdat
// (only if bytes are held), StFin; rejected write StIdle, StChk, StFin; accepted
// write StIdle, StChk, StSlot, StStore, StArd, StAchk, StFin, with StArd and
// StAchk again for each byte that assembly advances. One request is in work at a
// time; the next is taken once the result is registered. After reset a clearing
// pass over all CAPACITY (4096) slots runs before the first request is taken; all control state resets asynchronously.
module byte_stream_reassembler
  import bsr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // byte_index [31:0], byte_value [39:32]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]          s_axis_tuser,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // read_byte [7:0], assembled_next [39:8], unassembled_count [52:40],
  // buffered_count [65:53], stream_ended [66], zero [71:67]
  output logic [OutDataW-1:0] m_axis_tdata,
  // read_valid [0], accepted [1]
  output logic [1:0]          m_axis_tuser
);

  localparam logic [3:0] StInit  = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StChk   = 4'd2;
  localparam logic [3:0] StSlot  = 4'd3;
  localparam logic [3:0] StStore = 4'd4;
  localparam logic [3:0] StArd   = 4'd5;
  localparam logic [3:0] StAchk  = 4'd6;
  localparam logic [3:0] StRdat  = 4'd7;
  localparam logic [3:0] StFin   = 4'd8;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(CAPACITY - 1);

  logic [8:0] ring_mem [CAPACITY];

  logic [3:0]          state_q, state_d;
  logic [SlotW-1:0]    clr_q, clr_d;
  logic [IdxW-1:0]     nu_q, nu_d;
  logic [SlotW-1:0]    nu_slot_q, nu_slot_d;
  logic [SlotW-1:0]    fu_slot_q, fu_slot_d;
  logic [CntW-1:0]     held_q, held_d;
  logic [CntW-1:0]     pend_q, pend_d;
  logic [IdxW-1:0]     end_idx_q, end_idx_d;
  logic                end_known_q, end_known_d;
  logic                m_valid_q, m_valid_d;

  logic [IdxW-1:0]     idx_q, idx_d;
  logic [7:0]          val_q, val_d;
  logic                fin_q, fin_d;
  logic [SlotW-1:0]    off_q, off_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic                acc_q, acc_d;
  logic                rvalid_q, rvalid_d;
  logic [7:0]          rbyte_q, rbyte_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic [1:0]          out_user_q, out_user_d;

  logic                mem_re;
  logic [SlotW-1:0]    mem_raddr;
  logic                mem_we;
  logic [SlotW-1:0]    mem_waddr;
  logic [8:0]          mem_wdata;
  logic [8:0]          mem_rdata_q;

  logic [IdxW-1:0]     offset;
  logic [CntW-1:0]     room;
  logic [SlotW:0]      slot_sum;
  logic                ended;

  assign offset   = idx_q - nu_q;
  assign room     = CntW'(CAPACITY) - held_q;
  assign slot_sum = {1'b0, nu_slot_q} + {1'b0, off_q};
  assign ended    = end_known_q && (end_idx_q <= nu_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    nu_d        = nu_q;
    nu_slot_d   = nu_slot_q;
    fu_slot_d   = fu_slot_q;
    held_d      = held_q;
    pend_d      = pend_q;
    end_idx_d   = end_idx_q;
    end_known_d = end_known_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    idx_d       = idx_q;
    val_d       = val_q;
    fin_d       = fin_q;
    off_d       = off_q;
    slot_d      = slot_q;
    acc_d       = acc_q;
    rvalid_d    = rvalid_q;
    rbyte_d     = rbyte_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    mem_re      = 1'b0;
    mem_raddr   = fu_slot_q;
    mem_we      = 1'b0;
    mem_waddr   = nu_slot_q;
    mem_wdata   = '0;
    unique case (state_q)
      StInit: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == LastSlot) begin
          state_d = StIdle;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      StIdle: begin
        if (s_axis_tvalid) begin
          idx_d    = s_axis_tdata[31:0];
          val_d    = s_axis_tdata[39:32];
          fin_d    = s_axis_tlast;
          acc_d    = 1'b0;
          rvalid_d = 1'b0;
          rbyte_d  = '0;
          unique case (s_axis_tuser)
            OpWrite: state_d = StChk;
            OpEnd: begin
              end_idx_d   = s_axis_tdata[31:0];
              end_known_d = 1'b1;
              state_d     = StFin;
            end
            OpRead: begin
              if (held_q != '0) begin
                mem_re  = 1'b1;
                state_d = StRdat;
              end else begin
                state_d = StFin;
              end
            end
            default: state_d = StFin;
          endcase
        end
      end
      StChk: begin
        if (fin_q) begin
          end_idx_d   = idx_q + 1'b1;
          end_known_d = 1'b1;
        end
        if (offset < IdxW'(room)) begin
          acc_d   = 1'b1;
          off_d   = offset[SlotW-1:0];
          state_d = StSlot;
        end else begin
          state_d = StFin;
        end
      end
      StSlot: begin
        if (slot_sum >= (SlotW + 1)'(CAPACITY)) begin
          slot_d = SlotW'(slot_sum - (SlotW + 1)'(CAPACITY));
        end else begin
          slot_d = slot_sum[SlotW-1:0];
        end
        mem_re    = 1'b1;
        mem_raddr = slot_d;
        state_d   = StStore;
      end
      StStore: begin
        if (!mem_rdata_q[8]) begin
          mem_we    = 1'b1;
          mem_waddr = slot_q;
          mem_wdata = {1'b1, val_q};
          pend_d    = pend_q + 1'b1;
        end
        state_d = StArd;
      end
      StArd: begin
        mem_re    = 1'b1;
        mem_raddr = nu_slot_q;
        state_d   = StAchk;
      end
      StAchk: begin
        if (mem_rdata_q[8]) begin
          mem_we    = 1'b1;
          mem_waddr = nu_slot_q;
          mem_wdata = {1'b0, mem_rdata_q[7:0]};
          pend_d    = pend_q - 1'b1;
          held_d    = held_q + 1'b1;
          nu_d      = nu_q + 1'b1;
          nu_slot_d = (nu_slot_q == LastSlot) ? '0 : nu_slot_q + 1'b1;
          state_d   = StArd;
        end else begin
          state_d = StFin;
        end
      end
      StRdat: begin
        rvalid_d  = 1'b1;
        rbyte_d   = mem_rdata_q[7:0];
        held_d    = held_q - 1'b1;
        fu_slot_d = (fu_slot_q == LastSlot) ? '0 : fu_slot_q + 1'b1;
        state_d   = StFin;
      end
      StFin: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          out_user_d = {acc_q, rvalid_q};
          out_data_d = {5'b0, ended, CountOutW'(held_q), CountOutW'(pend_q), nu_q, rbyte_q};
          state_d    = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StInit;
      clr_q       <= '0;
      nu_q        <= '0;
      nu_slot_q   <= '0;
      fu_slot_q   <= '0;
      held_q      <= '0;
      pend_q      <= '0;
      end_idx_q   <= '0;
      end_known_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      nu_q        <= nu_d;
      nu_slot_q   <= nu_slot_d;
      fu_slot_q   <= fu_slot_d;
      held_q      <= held_d;
      pend_q      <= pend_d;
      end_idx_q   <= end_idx_d;
      end_known_q <= end_known_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    val_q      <= val_d;
    fin_q      <= fin_d;
    off_q      <= off_d;
    slot_q     <= slot_d;
    acc_q      <= acc_d;
    rvalid_q   <= rvalid_d;
    rbyte_q    <= rbyte_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= ring_mem[mem_raddr];
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

@@ hdl/bsr_checker.sv @@
// ----------------------------------------------------------------------------
// Byte stream reassembler checker
// Port-level properties of the reassembler, attached by a bind statement.
// ----------------------------------------------------------------------------
module bsr_checker
  import bsr_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser
);

  // A held result must not change until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // One request is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  // A result cannot be both a popped byte and a stored write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("read and write flags both set");

  // A result without a popped byte returns a zero byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'd0)
    else $error("byte returned without a read");

  // Stored and assembled bytes together never exceed the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[52:40]} + {1'b0, m_axis_tdata[65:53]})
                      <= 14'(CAPACITY))
    else $error("byte counts exceed capacity");

endmodule

bind byte_stream_reassembler bsr_checker u_bsr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
